@@ src/fat12_pkg.sv @@
// Shared types and constants for the FAT12 table engine.
// Used by fat12_store and fat12_table_engine; no dependencies.
`timescale 1ns / 1ps

package fat12_pkg;

    // Default size of the packed table store in bytes
    localparam int TABLE_BYTES_DEF = 6144;

    // Operation codes carried in the input tuser
    localparam logic [2:0] MODE_LOAD  = 3'd0;
    localparam logic [2:0] MODE_GET   = 3'd1;
    localparam logic [2:0] MODE_SET   = 3'd2;
    localparam logic [2:0] MODE_CHAIN = 3'd3;
    localparam logic [2:0] MODE_FREE  = 3'd4;

    // Result status codes
    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_BAD  = 2'd1;
    localparam logic [1:0] STAT_LOOP = 2'd2;

    // Entry values with a special meaning
    localparam logic [11:0] END_MARK  = 12'hFFF;
    localparam logic [11:0] LAST_GOOD = 12'hFF7;

    // Register map: index taken from paddr[2]
    localparam logic       REG_TOTAL     = 1'b0;
    localparam logic [11:0] TOTAL_RESET  = 12'd2847;

    // Request into the table store
    typedef struct packed {
        logic        rd;         // read the two bytes of entry 'cluster'
        logic        wr_word;    // write both bytes of entry 'cluster'
        logic        wr_byte;    // write one raw byte
        logic [11:0] cluster;
        logic [15:0] word;       // little-endian byte pair for wr_word
        logic [12:0] byte_addr;
        logic [7:0]  byte_data;
    } store_req_t;

endpackage

@@ src/fat12_table_engine.sv @@
// FAT12 table engine top level: stream channels, APB register, control FSM.
// Depends on fat12_pkg and fat12_store.
`timescale 1ns / 1ps

// Usage:
// One transaction on the s_ channel carries a mode in s_tuser and the operands
// in s_tdata; each one yields exactly one result transaction on the m_ channel
// (status in m_tuser, entry and count in m_tdata).
// Steps, from acceptance to result in the output register:
//   load_byte and unused modes : result registered on acceptance
//   get_entry, set_entry       : one store read, then write back
//   chain_length               : one store read per entry visited on the chain
//   free_count                 : one store read per cluster
// Each step waits on the registered store read of one entry; one item is in
// work at a time and s_tready is high only when idle.
// A finished result waits in the output register; if that register is still
// occupied the FSM holds the result and stops accepting until the slot drains.
// Reset (aresetn low, synchronous) empties the output, returns to idle and
// sets total_clusters to 2847; the table store is not cleared and must be
// loaded before its entries are read. total_clusters is written over APB at
// byte address 0, by the user only while idle; the block does not enforce this.

module fat12_table_engine #(
    parameter int TABLE_BYTES = fat12_pkg::TABLE_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // cluster[11:0], entry_in[23:12], byte_address[36:24],
                                   // byte_data[44:37], zero[47:45]
    input  logic [2:0]  s_tuser,   // mode[2:0]
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // entry_out[11:0], count[23:12]
    output logic [1:0]  m_tuser,   // status[1:0]
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import fat12_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_GET  = 5'b00010,
        S_WALK = 5'b00100,
        S_FREE = 5'b01000,
        S_HOLD = 5'b10000
    } state_t;

    // Input field unpacking
    logic [2:0]  in_mode;
    logic [11:0] in_cluster, in_entry;
    logic [12:0] in_baddr;
    logic [7:0]  in_bdata;
    logic        s_accept;

    assign in_mode    = s_tuser;
    assign in_cluster = s_tdata[11:0];
    assign in_entry   = s_tdata[23:12];
    assign in_baddr   = s_tdata[36:24];
    assign in_bdata   = s_tdata[44:37];

    // Registers
    state_t      state_reg, state_next;
    logic [2:0]  mode_reg, mode_next;
    logic [11:0] cluster_reg, cluster_next;
    logic [11:0] entry_in_reg, entry_in_next;
    logic [11:0] cur_reg, cur_next;
    logic [12:0] n_reg, n_next;
    logic [11:0] cnt_reg, cnt_next;
    logic [11:0] last_reg, last_next;
    logic [1:0]  res_status_reg, res_status_next;
    logic [11:0] res_entry_reg, res_entry_next;
    logic [11:0] res_count_reg, res_count_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [1:0]  m_status_reg, m_status_next;
    logic [11:0] m_entry_reg, m_entry_next;
    logic [11:0] m_count_reg, m_count_next;
    logic [11:0] total_reg, total_next;

    // Store interface
    store_req_t  req;
    logic [15:0] rd_word;
    logic [11:0] rd_entry;

    fat12_store #(
        .TABLE_BYTES(TABLE_BYTES)
    ) u_store (
        .aclk     (aclk),
        .req      (req),
        .rd_word  (rd_word),
        .rd_entry (rd_entry)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid & s_tready;

    // Control and datapath next-state logic
    logic        finish;
    logic [1:0]  fin_status;
    logic [11:0] fin_entry, fin_count;
    logic        out_free;
    logic [12:0] n_inc;
    logic        bad_entry;
    logic        hit;
    logic [11:0] cnt_sum;

    assign out_free  = ~m_tvalid_reg | m_tready;
    assign n_inc     = n_reg + 13'd1;
    assign bad_entry = (rd_entry == 12'd0) || ((rd_entry > LAST_GOOD) && (rd_entry != END_MARK));
    assign hit       = (rd_entry == 12'd0);
    assign cnt_sum   = cnt_reg + {11'd0, hit};

    always_comb begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        cluster_next    = cluster_reg;
        entry_in_next   = entry_in_reg;
        cur_next        = cur_reg;
        n_next          = n_reg;
        cnt_next        = cnt_reg;
        last_next       = last_reg;
        res_status_next = res_status_reg;
        res_entry_next  = res_entry_reg;
        res_count_next  = res_count_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_status_next   = m_status_reg;
        m_entry_next    = m_entry_reg;
        m_count_next    = m_count_reg;
        req             = '0;
        finish          = 1'b0;
        fin_status      = STAT_OK;
        fin_entry       = 12'd0;
        fin_count       = 12'd0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    mode_next     = in_mode;
                    cluster_next  = in_cluster;
                    entry_in_next = in_entry;
                    unique case (in_mode)
                        MODE_LOAD: begin
                            req.wr_byte   = 1'b1;
                            req.byte_addr = in_baddr;
                            req.byte_data = in_bdata;
                            finish        = 1'b1;
                        end
                        MODE_GET, MODE_SET: begin
                            req.rd      = 1'b1;
                            req.cluster = in_cluster;
                            state_next  = S_GET;
                        end
                        MODE_CHAIN: begin
                            n_next = 13'd0;
                            if (in_cluster == END_MARK) begin
                                finish = 1'b1;
                            end else begin
                                req.rd      = 1'b1;
                                req.cluster = in_cluster;
                                state_next  = S_WALK;
                            end
                        end
                        MODE_FREE: begin
                            cnt_next  = 12'd0;
                            last_next = (total_reg == 12'hFFF) ? 12'hFFF : total_reg + 12'd1;
                            if (total_reg == 12'd0) begin
                                finish = 1'b1;
                            end else begin
                                req.rd      = 1'b1;
                                req.cluster = 12'd2;
                                cur_next    = 12'd2;
                                state_next  = S_FREE;
                            end
                        end
                        default: begin
                            finish = 1'b1;
                        end
                    endcase
                end
            end
            S_GET: begin
                finish = 1'b1;
                if (mode_reg == MODE_GET) begin
                    fin_entry = rd_entry;
                end else begin
                    // keep the neighbor's nibble that shares a byte
                    req.wr_word = 1'b1;
                    req.cluster = cluster_reg;
                    req.word    = cluster_reg[0] ? {entry_in_reg, rd_word[3:0]}
                                                 : {rd_word[15:12], entry_in_reg};
                end
            end
            S_WALK: begin
                if (bad_entry) begin
                    finish     = 1'b1;
                    fin_status = STAT_BAD;
                end else if (n_inc > {1'b0, total_reg}) begin
                    finish     = 1'b1;
                    fin_status = STAT_LOOP;
                end else if (rd_entry == END_MARK) begin
                    finish    = 1'b1;
                    fin_count = n_inc[11:0];
                end else begin
                    // next link read overlaps with this check
                    req.rd      = 1'b1;
                    req.cluster = rd_entry;
                    n_next      = n_inc;
                end
            end
            S_FREE: begin
                if (cur_reg == last_reg) begin
                    finish    = 1'b1;
                    fin_count = cnt_sum;
                end else begin
                    req.rd      = 1'b1;
                    req.cluster = cur_reg + 12'd1;
                    cur_next    = cur_reg + 12'd1;
                    cnt_next    = cnt_sum;
                end
            end
            S_HOLD: begin
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // Output register: drain, then load from a held or a fresh result
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (state_reg == S_HOLD) begin
            if (out_free) begin
                m_tvalid_next = 1'b1;
                m_status_next = res_status_reg;
                m_entry_next  = res_entry_reg;
                m_count_next  = res_count_reg;
                state_next    = S_IDLE;
            end
        end else if (finish) begin
            if (out_free) begin
                m_tvalid_next = 1'b1;
                m_status_next = fin_status;
                m_entry_next  = fin_entry;
                m_count_next  = fin_count;
                state_next    = S_IDLE;
            end else begin
                res_status_next = fin_status;
                res_entry_next  = fin_entry;
                res_count_next  = fin_count;
                state_next      = S_HOLD;
            end
        end
    end

    // Configuration register write
    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == REG_TOTAL);

    always_comb begin
        total_next = total_reg;
        if (cfg_wr) begin
            total_next = pwdata[11:0];
        end
    end

    assign prdata = (paddr[2] == REG_TOTAL) ? {20'd0, total_reg} : 32'd0;

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            total_reg    <= TOTAL_RESET;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            total_reg    <= total_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        mode_reg       <= mode_next;
        cluster_reg    <= cluster_next;
        entry_in_reg   <= entry_in_next;
        cur_reg        <= cur_next;
        n_reg          <= n_next;
        cnt_reg        <= cnt_next;
        last_reg       <= last_next;
        res_status_reg <= res_status_next;
        res_entry_reg  <= res_entry_next;
        res_count_reg  <= res_count_next;
        m_status_reg   <= m_status_next;
        m_entry_reg    <= m_entry_next;
        m_count_reg    <= m_count_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {m_count_reg, m_entry_reg};

endmodule

@@ src/fat12_store.sv @@
// Packed FAT12 table store: even and odd byte banks, registered read.
// Depends on fat12_pkg (store_req_t).
`timescale 1ns / 1ps

module fat12_store #(
    parameter int TABLE_BYTES = fat12_pkg::TABLE_BYTES_DEF
) (
    input  logic                  aclk,
    input  fat12_pkg::store_req_t req,
    output logic [15:0]           rd_word,   // byte pair at n + n/2, low byte first
    output logic [11:0]           rd_entry   // unpacked entry of the last read
);
    import fat12_pkg::*;

    localparam int DEPTH_E = (TABLE_BYTES + 1) / 2;
    localparam int DEPTH_O = TABLE_BYTES / 2;
    localparam int IDX_W   = $clog2(DEPTH_E);
    localparam logic [13:0] TB_LIM = 14'(TABLE_BYTES);

    logic [7:0] mem_e [DEPTH_E];
    logic [7:0] mem_o [DEPTH_O];

    // Byte offsets of the entry: off holds the low byte, off_hi the high byte
    logic [12:0] off, off_hi;
    logic        lo_ok, hi_ok, byte_ok;
    logic [IDX_W-1:0] idx_lo, idx_hi, even_idx, odd_idx, byte_idx;

    assign off      = {1'b0, req.cluster} + {2'b00, req.cluster[11:1]};
    assign off_hi   = off + 13'd1;
    assign lo_ok    = ({1'b0, off} < TB_LIM);
    assign hi_ok    = ({1'b0, off_hi} < TB_LIM);
    assign byte_ok  = ({1'b0, req.byte_addr} < TB_LIM);
    assign idx_lo   = off[IDX_W:1];
    assign idx_hi   = off_hi[IDX_W:1];
    assign byte_idx = req.byte_addr[IDX_W:1];

    // One byte of the pair is always even, the other odd
    assign even_idx = off[0] ? idx_hi : idx_lo;
    assign odd_idx  = off[0] ? idx_lo : idx_hi;

    // Bank write port selection
    logic             e_we, o_we;
    logic [IDX_W-1:0] e_idx, o_idx;
    logic [7:0]       e_d, o_d;

    always_comb begin
        e_we  = 1'b0;
        o_we  = 1'b0;
        e_idx = even_idx;
        o_idx = odd_idx;
        e_d   = req.word[7:0];
        o_d   = req.word[15:8];
        if (req.wr_byte) begin
            e_we  = byte_ok & ~req.byte_addr[0];
            o_we  = byte_ok & req.byte_addr[0];
            e_idx = byte_idx;
            o_idx = byte_idx;
            e_d   = req.byte_data;
            o_d   = req.byte_data;
        end else if (req.wr_word) begin
            if (off[0]) begin
                o_we = lo_ok;
                o_d  = req.word[7:0];
                e_we = hi_ok;
                e_d  = req.word[15:8];
            end else begin
                e_we = lo_ok;
                e_d  = req.word[7:0];
                o_we = hi_ok;
                o_d  = req.word[15:8];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (e_we) begin
            mem_e[e_idx] <= e_d;
        end
        if (o_we) begin
            mem_o[o_idx] <= o_d;
        end
    end

    // Registered read of both banks plus the flags needed to reassemble
    logic [7:0] e_q, o_q;
    logic       off_odd_q, lo_ok_q, hi_ok_q, n_odd_q;

    always_ff @(posedge aclk) begin
        if (req.rd) begin
            e_q       <= mem_e[even_idx];
            o_q       <= mem_o[odd_idx];
            off_odd_q <= off[0];
            lo_ok_q   <= lo_ok;
            hi_ok_q   <= hi_ok;
            n_odd_q   <= req.cluster[0];
        end
    end

    // Bytes beyond the store read as zero
    logic [7:0] lo_b, hi_b;
    assign lo_b     = lo_ok_q ? (off_odd_q ? o_q : e_q) : 8'h00;
    assign hi_b     = hi_ok_q ? (off_odd_q ? e_q : o_q) : 8'h00;
    assign rd_word  = {hi_b, lo_b};
    assign rd_entry = n_odd_q ? rd_word[15:4] : rd_word[11:0];

endmodule
